### design/spd_pkg.sv
`timescale 1ns / 1ps
package spd_pkg;

  localparam int CORDIC_ITERATIONS = 24;
  localparam int ITER_W = 5;
  localparam int CW = 34;

  localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(CORDIC_ITERATIONS - 1);
  localparam logic [ITER_W-1:0] SQRT_LAST = ITER_W'(31);

  localparam logic signed [CW-1:0] GAIN_INV = 34'sd652032874;
  localparam logic signed [CW-1:0] Q30_ONE  = 34'sd1073741824;
  localparam logic signed [CW-1:0] Z_BIAS   = 34'sd536870912;
  // fractional part of pi in Q32 (integer part 3 is added separately)
  localparam logic [31:0] PI_FRAC      = 32'h243F_6A89;
  localparam logic [28:0] DIST_MAX     = 29'h1FFF_FFFF;
  localparam logic [22:0] RADIUS_RESET = 23'd6378137;

  typedef enum logic [4:0] {
    S_IDLE, S_CHECK, S_SC_LOAD, S_SC_RUN, S_SC_END,
    S_MUL_CC, S_MUL_V2, S_MUL_U2, S_MUL_T1, S_MUL_T2, S_SUM1, S_SUM2,
    S_SQ1, S_MUL_H2, S_SQ2_LOAD, S_SQ2, S_AS_LOAD, S_AS_RUN, S_AS_END,
    S_MUL_M, S_M_SUM, S_MUL_D, S_DIST, S_DECIDE, S_FIN
  } state_t;

  // atan(2^-i) in binary angle units (2^32 per turn)
  function automatic logic [29:0] atan_lut(input logic [ITER_W-1:0] idx);
    logic [29:0] r;
    case (idx)
      5'd0:  r = 30'd536870912;
      5'd1:  r = 30'd316933406;
      5'd2:  r = 30'd167458907;
      5'd3:  r = 30'd85004756;
      5'd4:  r = 30'd42667331;
      5'd5:  r = 30'd21354465;
      5'd6:  r = 30'd10679838;
      5'd7:  r = 30'd5340245;
      5'd8:  r = 30'd2670163;
      5'd9:  r = 30'd1335087;
      5'd10: r = 30'd667544;
      5'd11: r = 30'd333772;
      5'd12: r = 30'd166886;
      5'd13: r = 30'd83443;
      5'd14: r = 30'd41722;
      5'd15: r = 30'd20861;
      5'd16: r = 30'd10430;
      5'd17: r = 30'd5215;
      5'd18: r = 30'd2608;
      5'd19: r = 30'd1304;
      5'd20: r = 30'd652;
      5'd21: r = 30'd326;
      5'd22: r = 30'd163;
      5'd23: r = 30'd81;
      5'd24: r = 30'd41;
      5'd25: r = 30'd20;
      5'd26: r = 30'd10;
      5'd27: r = 30'd5;
      5'd28: r = 30'd3;
      5'd29: r = 30'd1;
      5'd30: r = 30'd1;
      default: r = 30'd0;
    endcase
    return r;
  endfunction

endpackage

### design/spd_if.sv
`timescale 1ns / 1ps
interface spd_ping_if;
  logic               valid;
  logic               ready;
  logic [31:0]        user_id;
  logic signed [31:0] longitude;
  logic signed [31:0] latitude;
  logic [23:0]        accuracy;
  logic               prior_flag;

  modport source(output valid, user_id, longitude, latitude, accuracy, prior_flag,
                 input ready);
  modport sink(input valid, user_id, longitude, latitude, accuracy, prior_flag,
               output ready);
endinterface

interface spd_result_if;
  logic        valid;
  logic        ready;
  logic        still;
  logic [28:0] distance;

  modport source(output valid, still, distance, input ready);
  modport sink(input valid, still, distance, output ready);
endinterface

### design/stationary_point_detector.sv
`timescale 1ns / 1ps
// Stationary point detector.
// in_ping (valid/ready) carries one location ping: user id, longitude and
// latitude as binary angles, accuracy in 1/16 m and an upstream still flag.
// out_res (valid/ready) returns one result per ping: still flag and the
// haversine distance to the held anchor in 1/16 m, saturating.
// cfg_we/cfg_wdata write the sphere radius in metres; write only when idle.
// One ping at a time: in_ping.ready only in idle.
// A ping with no anchor or a new user goes from S_CHECK straight to S_FIN,
// which loads the output register. A compared ping runs the shared CORDIC
// step unit (four sin/cos runs and one arcsine run) and two 32-step bitwise
// square roots on the same sequencer, between S_CHECK and S_FIN.
// in_ping.ready comes back as the result is loaded into the output register.
// One shared 33x33 multiplier covers all products, one product per cycle.
// Reset (rst_n, synchronous) drops the anchor and loads the default radius.
// The result sits in an output register; if out_res stalls, the sequencer
// holds the finished ping in its last state and takes no new ping.
module stationary_point_detector (
  input  logic               clk,
  input  logic               rst_n,
  spd_ping_if.sink           in_ping,
  spd_result_if.source       out_res,
  input  logic               cfg_we,
  input  logic [22:0]        cfg_wdata
);

  spd_pkg::state_t state_r, state_nxt;

  // config and anchor
  logic [22:0] radius_r;
  logic        anc_valid_r;
  logic [31:0] anc_user_r, anc_lon_r, anc_lat_r;
  logic [23:0] anc_acc_r;

  // pending ping
  logic [31:0] pend_user_r, pend_lon_r, pend_lat_r;
  logic [23:0] pend_acc_r;
  logic        pend_prior_r;

  // CORDIC working set
  logic [1:0]                          sc_idx_r, sc_idx_nxt;
  logic signed [spd_pkg::CW-1:0]       cx_r, cx_nxt, cy_r, cy_nxt, cz_r, cz_nxt;
  logic [1:0]                          q_r, q_nxt;
  logic [spd_pkg::ITER_W-1:0]          it_r, it_nxt;

  // intermediate values
  logic signed [31:0] u_r, u_nxt, v_r, v_nxt, ca_r, ca_nxt, cb_r, cb_nxt;
  logic signed [31:0] cc_r, cc_nxt;
  logic [60:0]        v2_r, v2_nxt;
  logic signed [63:0] a_r, a_nxt;
  logic [61:0]        t_r, t_nxt;
  logic [29:0]        p2_r, p2_nxt;
  logic [63:0]        sq_v_r, sq_v_nxt, sq_res_r, sq_res_nxt;
  logic [30:0]        hq_r, hq_nxt;
  logic [30:0]        z_r, z_nxt;
  logic [63:0]        p_r, p_nxt;
  logic [31:0]        m_r, m_nxt;
  logic [28:0]        d_r, d_nxt;
  logic               still_r, still_nxt, take_r, take_nxt;

  // output register
  logic        out_valid_r;
  logic        out_still_r;
  logic [28:0] out_dist_r;

  logic in_fire, fin_go;
  assign in_ping.ready = (state_r == spd_pkg::S_IDLE);
  assign in_fire = in_ping.valid && in_ping.ready;
  assign fin_go  = (state_r == spd_pkg::S_FIN) && (!out_valid_r || out_res.ready);

  assign out_res.valid    = out_valid_r;
  assign out_res.still    = out_still_r;
  assign out_res.distance = out_dist_r;

  // shared multiplier
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;
  logic [30:0]        mag;
  assign mag   = cc_r[31] ? 31'(-cc_r) : cc_r[30:0];
  assign mul_p = mul_a * mul_b;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      spd_pkg::S_MUL_CC: begin mul_a = {ca_r[31], ca_r}; mul_b = {cb_r[31], cb_r}; end
      spd_pkg::S_MUL_V2: begin mul_a = {v_r[31], v_r};   mul_b = {v_r[31], v_r};   end
      spd_pkg::S_MUL_U2: begin mul_a = {u_r[31], u_r};   mul_b = {u_r[31], u_r};   end
      spd_pkg::S_MUL_T1: begin mul_a = {2'b0, v2_r[60:30]}; mul_b = {2'b0, mag}; end
      spd_pkg::S_MUL_T2: begin mul_a = {3'b0, v2_r[29:0]};  mul_b = {2'b0, mag}; end
      spd_pkg::S_MUL_H2: begin mul_a = {2'b0, sq_res_r[30:0]};
                               mul_b = {2'b0, sq_res_r[30:0]}; end
      spd_pkg::S_MUL_M:  begin mul_a = {2'b0, z_r}; mul_b = {1'b0, spd_pkg::PI_FRAC}; end
      spd_pkg::S_MUL_D:  begin mul_a = {10'b0, radius_r}; mul_b = {1'b0, m_r}; end
      default: ;
    endcase
  end

  // shared CORDIC step; vectoring drives y to zero, rotation drives z to zero
  logic                          vec, rot;
  logic signed [spd_pkg::CW-1:0] sh_x, sh_y, at;
  assign vec  = (state_r == spd_pkg::S_AS_RUN);
  assign rot  = vec ? !(cy_r > 0) : !cz_r[spd_pkg::CW-1];
  assign sh_x = cx_r >>> it_r;
  assign sh_y = cy_r >>> it_r;
  assign at   = $signed({4'b0, spd_pkg::atan_lut(it_r)});

  // angle for the current sin/cos run
  logic [31:0] ang, ang_sh;
  always_comb begin
    case (sc_idx_r)
      2'd0:    ang = (pend_lat_r - anc_lat_r) >> 1;
      2'd1:    ang = (pend_lon_r - anc_lon_r) >> 1;
      2'd2:    ang = pend_lat_r;
      default: ang = anc_lat_r;
    endcase
  end
  assign ang_sh = ang + 32'h2000_0000;

  // clamp and quadrant map
  logic signed [spd_pkg::CW-1:0] xc, yc;
  logic signed [31:0]            cs, sn;
  assign xc = (cx_r > spd_pkg::Q30_ONE) ? spd_pkg::Q30_ONE :
              (cx_r < -spd_pkg::Q30_ONE) ? -spd_pkg::Q30_ONE : cx_r;
  assign yc = (cy_r > spd_pkg::Q30_ONE) ? spd_pkg::Q30_ONE :
              (cy_r < -spd_pkg::Q30_ONE) ? -spd_pkg::Q30_ONE : cy_r;
  always_comb begin
    case (q_r)
      2'd0:    begin cs = xc[31:0];    sn = yc[31:0];    end
      2'd1:    begin cs = -yc[31:0];   sn = xc[31:0];    end
      2'd2:    begin cs = -xc[31:0];   sn = -yc[31:0];   end
      default: begin cs = yc[31:0];    sn = -xc[31:0];   end
    endcase
  end

  // square root step: one result bit per cycle
  logic [63:0] sq_bit, sq_trial;
  assign sq_bit   = 64'h4000_0000_0000_0000 >> {it_r, 1'b0};
  assign sq_trial = sq_res_r + sq_bit;

  logic signed [63:0] sum_s;
  logic [63:0]        dd;
  logic [24:0]        lim;
  assign sum_s = cc_r[31] ? a_r - $signed({2'b0, t_r}) : a_r + $signed({2'b0, t_r});
  assign dd    = (p_r + 64'h0200_0000) >> 26;
  assign lim   = {1'b0, pend_acc_r} + {1'b0, anc_acc_r};

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      spd_pkg::S_IDLE:     if (in_fire) state_nxt = spd_pkg::S_CHECK;
      spd_pkg::S_CHECK:
        state_nxt = (anc_valid_r && pend_user_r == anc_user_r) ?
                    spd_pkg::S_SC_LOAD : spd_pkg::S_FIN;
      spd_pkg::S_SC_LOAD:  state_nxt = spd_pkg::S_SC_RUN;
      spd_pkg::S_SC_RUN:   if (it_r == spd_pkg::ITER_LAST) state_nxt = spd_pkg::S_SC_END;
      spd_pkg::S_SC_END:
        state_nxt = (sc_idx_r == 2'd3) ? spd_pkg::S_MUL_CC : spd_pkg::S_SC_LOAD;
      spd_pkg::S_MUL_CC:   state_nxt = spd_pkg::S_MUL_V2;
      spd_pkg::S_MUL_V2:   state_nxt = spd_pkg::S_MUL_U2;
      spd_pkg::S_MUL_U2:   state_nxt = spd_pkg::S_MUL_T1;
      spd_pkg::S_MUL_T1:   state_nxt = spd_pkg::S_MUL_T2;
      spd_pkg::S_MUL_T2:   state_nxt = spd_pkg::S_SUM1;
      spd_pkg::S_SUM1:     state_nxt = spd_pkg::S_SUM2;
      spd_pkg::S_SUM2:     state_nxt = spd_pkg::S_SQ1;
      spd_pkg::S_SQ1:      if (it_r == spd_pkg::SQRT_LAST) state_nxt = spd_pkg::S_MUL_H2;
      spd_pkg::S_MUL_H2:   state_nxt = spd_pkg::S_SQ2_LOAD;
      spd_pkg::S_SQ2_LOAD: state_nxt = spd_pkg::S_SQ2;
      spd_pkg::S_SQ2:      if (it_r == spd_pkg::SQRT_LAST) state_nxt = spd_pkg::S_AS_LOAD;
      spd_pkg::S_AS_LOAD:  state_nxt = spd_pkg::S_AS_RUN;
      spd_pkg::S_AS_RUN:   if (it_r == spd_pkg::ITER_LAST) state_nxt = spd_pkg::S_AS_END;
      spd_pkg::S_AS_END:   state_nxt = spd_pkg::S_MUL_M;
      spd_pkg::S_MUL_M:    state_nxt = spd_pkg::S_M_SUM;
      spd_pkg::S_M_SUM:    state_nxt = spd_pkg::S_MUL_D;
      spd_pkg::S_MUL_D:    state_nxt = spd_pkg::S_DIST;
      spd_pkg::S_DIST:     state_nxt = spd_pkg::S_DECIDE;
      spd_pkg::S_DECIDE:   state_nxt = spd_pkg::S_FIN;
      spd_pkg::S_FIN:      if (fin_go) state_nxt = spd_pkg::S_IDLE;
      default:             state_nxt = spd_pkg::S_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    sc_idx_nxt = sc_idx_r;
    cx_nxt = cx_r; cy_nxt = cy_r; cz_nxt = cz_r; q_nxt = q_r; it_nxt = it_r;
    u_nxt = u_r; v_nxt = v_r; ca_nxt = ca_r; cb_nxt = cb_r; cc_nxt = cc_r;
    v2_nxt = v2_r; a_nxt = a_r; t_nxt = t_r; p2_nxt = p2_r;
    sq_v_nxt = sq_v_r; sq_res_nxt = sq_res_r; hq_nxt = hq_r; z_nxt = z_r;
    p_nxt = p_r; m_nxt = m_r; d_nxt = d_r; still_nxt = still_r; take_nxt = take_r;
    case (state_r)
      spd_pkg::S_CHECK: begin
        sc_idx_nxt = 2'd0;
        d_nxt      = '0;
        still_nxt  = pend_prior_r;
        take_nxt   = 1'b1;
      end
      spd_pkg::S_SC_LOAD: begin
        cx_nxt = spd_pkg::GAIN_INV;
        cy_nxt = '0;
        cz_nxt = $signed({4'b0, ang_sh[29:0]}) - spd_pkg::Z_BIAS;
        q_nxt  = ang_sh[31:30];
        it_nxt = '0;
      end
      spd_pkg::S_SC_RUN, spd_pkg::S_AS_RUN: begin
        if (rot) begin
          cx_nxt = cx_r - sh_y; cy_nxt = cy_r + sh_x; cz_nxt = cz_r - at;
        end else begin
          cx_nxt = cx_r + sh_y; cy_nxt = cy_r - sh_x; cz_nxt = cz_r + at;
        end
        it_nxt = it_r + 1'b1;
      end
      spd_pkg::S_SC_END: begin
        case (sc_idx_r)
          2'd0:    u_nxt  = sn;
          2'd1:    v_nxt  = sn;
          2'd2:    ca_nxt = cs;
          default: cb_nxt = cs;
        endcase
        sc_idx_nxt = sc_idx_r + 1'b1;
      end
      spd_pkg::S_MUL_CC: cc_nxt = mul_p[61:30];
      spd_pkg::S_MUL_V2: v2_nxt = mul_p[60:0];
      spd_pkg::S_MUL_U2: a_nxt  = mul_p[63:0];
      spd_pkg::S_MUL_T1: t_nxt  = mul_p[61:0];
      spd_pkg::S_MUL_T2: p2_nxt = mul_p[59:30];
      spd_pkg::S_SUM1:   t_nxt  = t_r + {32'b0, p2_r};
      spd_pkg::S_SUM2: begin
        if (sum_s < 0)
          sq_v_nxt = '0;
        else if (sum_s > 64'sh1000_0000_0000_0000)
          sq_v_nxt = 64'h1000_0000_0000_0000;
        else
          sq_v_nxt = sum_s;
        sq_res_nxt = '0;
        it_nxt     = '0;
      end
      spd_pkg::S_SQ1, spd_pkg::S_SQ2: begin
        if (sq_v_r >= sq_trial) begin
          sq_v_nxt   = sq_v_r - sq_trial;
          sq_res_nxt = (sq_res_r >> 1) + sq_bit;
        end else begin
          sq_res_nxt = sq_res_r >> 1;
        end
        it_nxt = it_r + 1'b1;
      end
      spd_pkg::S_MUL_H2: begin
        hq_nxt   = sq_res_r[30:0];
        sq_v_nxt = mul_p[63:0];
      end
      spd_pkg::S_SQ2_LOAD: begin
        sq_v_nxt   = 64'h1000_0000_0000_0000 - sq_v_r;
        sq_res_nxt = '0;
        it_nxt     = '0;
      end
      spd_pkg::S_AS_LOAD: begin
        cx_nxt = $signed({3'b0, sq_res_r[30:0]});
        cy_nxt = $signed({3'b0, hq_r});
        cz_nxt = '0;
        it_nxt = '0;
      end
      spd_pkg::S_AS_END: begin
        if (cz_r < 0)                    z_nxt = '0;
        else if (cz_r > spd_pkg::Q30_ONE) z_nxt = 31'h4000_0000;
        else                             z_nxt = cz_r[30:0];
      end
      spd_pkg::S_MUL_M: p_nxt = mul_p[63:0];
      spd_pkg::S_M_SUM:
        m_nxt = 32'({1'b0, z_r, 1'b0} + {2'b0, z_r} + 33'((p_r + 64'h8000_0000) >> 32));
      spd_pkg::S_MUL_D: p_nxt = mul_p[63:0];
      spd_pkg::S_DIST:  d_nxt = (dd > {35'b0, spd_pkg::DIST_MAX}) ? spd_pkg::DIST_MAX : dd[28:0];
      spd_pkg::S_DECIDE: begin
        if (d_r < {4'b0, lim}) begin
          still_nxt = 1'b1;
          take_nxt  = 1'b0;
        end else begin
          still_nxt = pend_prior_r;
          take_nxt  = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= spd_pkg::S_IDLE;
      radius_r    <= spd_pkg::RADIUS_RESET;
      anc_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) radius_r <= cfg_wdata;
      if (fin_go && take_r) anc_valid_r <= 1'b1;
      if (fin_go)              out_valid_r <= 1'b1;
      else if (out_res.ready)  out_valid_r <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      pend_user_r  <= in_ping.user_id;
      pend_lon_r   <= in_ping.longitude;
      pend_lat_r   <= in_ping.latitude;
      pend_acc_r   <= in_ping.accuracy;
      pend_prior_r <= in_ping.prior_flag;
    end
    if (fin_go) begin
      out_still_r <= still_r;
      out_dist_r  <= d_r;
      if (take_r) begin
        anc_user_r <= pend_user_r;
        anc_lon_r  <= pend_lon_r;
        anc_lat_r  <= pend_lat_r;
        anc_acc_r  <= pend_acc_r;
      end
    end
    sc_idx_r <= sc_idx_nxt;
    cx_r <= cx_nxt; cy_r <= cy_nxt; cz_r <= cz_nxt; q_r <= q_nxt; it_r <= it_nxt;
    u_r <= u_nxt; v_r <= v_nxt; ca_r <= ca_nxt; cb_r <= cb_nxt; cc_r <= cc_nxt;
    v2_r <= v2_nxt; a_r <= a_nxt; t_r <= t_nxt; p2_r <= p2_nxt;
    sq_v_r <= sq_v_nxt; sq_res_r <= sq_res_nxt; hq_r <= hq_nxt; z_r <= z_nxt;
    p_r <= p_nxt; m_r <= m_nxt; d_r <= d_nxt; still_r <= still_nxt; take_r <= take_nxt;
  end

  // checks
  a_accept_to_check: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r == spd_pkg::S_CHECK)
    else $error("ping transfer did not start the anchor check");

  a_anchor_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    anc_valid_r |=> anc_valid_r)
    else $error("anchor lost without reset");

  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == spd_pkg::S_FIN))
    else $error("result raised outside the finish state");

  a_cordic_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == spd_pkg::S_SC_RUN || state_r == spd_pkg::S_AS_RUN)
      |-> it_r <= spd_pkg::ITER_LAST)
    else $error("CORDIC step count overrun");

endmodule

### bench/tb.sv
`timescale 1ns / 1ps
module tb;

  // Expected outcome of one ping.
  typedef struct {
    bit        still;
    bit [28:0] distance;
  } stay_result_t;

  // Anchor tracker and haversine distance predictor.
  // The expected results wait in a FIFO until the result channel delivers them.
  class stay_scoreboard;
    bit [22:0]    radius_m;
    bit           have_anchor;
    bit [31:0]    anchor_user, anchor_lon, anchor_lat;
    bit [23:0]    anchor_acc;
    stay_result_t expected_q[$];
    int           mismatches;
    int           failures;
    longint       atan_bam[32];

    function new();
      atan_bam = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                   10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
                   83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
                   81, 41, 20, 10, 5, 3, 1, 1, 0};
      radius_m    = spd_pkg::RADIUS_RESET;
      have_anchor = 0;
      anchor_user = 0;
      anchor_lon  = 0;
      anchor_lat  = 0;
      anchor_acc  = 0;
      mismatches  = 0;
      failures    = 0;
    endfunction

    function longint clamp(longint v, longint lo, longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res, b;
      res = 0;
      b   = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= res + b) begin
          v   = v - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return res;
    endfunction

    // Rotation CORDIC after folding the angle to the nearest quarter turn.
    function void sin_cos(input bit [31:0] ang, output longint cs, output longint sn);
      bit [31:0] sh;
      bit [1:0]  quad;
      longint    x, y, z, dx, dy;
      sh   = ang + 32'h2000_0000;
      quad = sh[31:30];
      x    = 652032874;
      y    = 0;
      z    = longint'({2'b00, sh[29:0]}) - 64'sd536870912;
      for (int i = 0; i < spd_pkg::CORDIC_ITERATIONS && i < 32; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x = x - dx; y = y + dy; z = z - atan_bam[i];
        end else begin
          x = x + dx; y = y - dy; z = z + atan_bam[i];
        end
      end
      x = clamp(x, -(64'sd1 << 30), 64'sd1 << 30);
      y = clamp(y, -(64'sd1 << 30), 64'sd1 << 30);
      case (quad)
        2'd0: begin cs = x;  sn = y;  end
        2'd1: begin cs = -y; sn = x;  end
        2'd2: begin cs = -x; sn = -y; end
        default: begin cs = y; sn = -x; end
      endcase
    endfunction

    // Vectoring CORDIC: angle of (c, h) in binary angle units.
    function longint arcsine(longint c, longint h);
      longint x, y, z, dx, dy;
      x = c; y = h; z = 0;
      for (int i = 0; i < spd_pkg::CORDIC_ITERATIONS && i < 32; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y > 0) begin
          x = x + dx; y = y - dy; z = z + atan_bam[i];
        end else begin
          x = x - dx; y = y + dy; z = z - atan_bam[i];
        end
      end
      return clamp(z, 0, 64'sd1 << 30);
    endfunction

    function bit [28:0] haversine_16(bit [31:0] lon_a, bit [31:0] lat_a,
                                     bit [31:0] lon_b, bit [31:0] lat_b);
      bit [31:0]       dlat, dlon;
      longint          c0, u, c1, v, ca, cb, s0, cc, term, a, hq, cq, z;
      longint unsigned v2, mag, m, d;
      dlat = lat_a - lat_b;
      dlon = lon_a - lon_b;
      sin_cos(dlat >> 1, c0, u);
      sin_cos(dlon >> 1, c1, v);
      sin_cos(lat_a, ca, s0);
      sin_cos(lat_b, cb, s0);
      cc   = (ca * cb) >>> 30;
      v2   = v * v;
      mag  = (cc < 0) ? -cc : cc;
      term = (v2 >> 30) * mag + (((v2 & 64'h3FFF_FFFF) * mag) >> 30);
      if (cc < 0) term = -term;
      a  = clamp(u * u + term, 0, 64'sd1 << 60);
      hq = int_sqrt(a);
      cq = int_sqrt((64'd1 << 60) - hq * hq);
      z  = arcsine(cq, hq);
      m  = (longint'(z) * 64'd13493037705 + (64'd1 << 31)) >> 32;
      d  = (64'(radius_m) * m + (64'd1 << 25)) >> 26;
      return (d > 64'(spd_pkg::DIST_MAX)) ? spd_pkg::DIST_MAX : d[28:0];
    endfunction

    function void note_ping(bit [31:0] user, bit [31:0] lon, bit [31:0] lat,
                            bit [23:0] acc, bit prior);
      stay_result_t r;
      bit           replace;
      r.still    = prior;
      r.distance = 0;
      replace    = 1;
      if (have_anchor && user == anchor_user) begin
        r.distance = haversine_16(lon, lat, anchor_lon, anchor_lat);
        if (30'(r.distance) < 30'(acc) + 30'(anchor_acc)) begin
          r.still = 1;
          replace = 0;
        end
      end
      if (replace) begin
        have_anchor = 1;
        anchor_user = user;
        anchor_lon  = lon;
        anchor_lat  = lat;
        anchor_acc  = acc;
      end
      expected_q.push_back(r);
    endfunction

    function void check_result(bit still, bit [28:0] distance);
      stay_result_t r;
      if (expected_q.size() == 0) begin
        failures++;
        if (mismatches++ < 10)
          $display("unexpected result: still=%0d distance=%0d", still, distance);
        return;
      end
      r = expected_q.pop_front();
      if (r.still !== still || r.distance !== distance) begin
        failures++;
        if (mismatches++ < 10)
          $display("mismatch: expected still=%0d distance=%0d, got still=%0d distance=%0d",
                   r.still, r.distance, still, distance);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [22:0] cfg_wdata;

  spd_ping_if   ping_ch();
  spd_result_if res_ch();

  stationary_point_detector dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ping   (ping_ch.sink),
    .out_res   (res_ch.source),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  stay_scoreboard sb;
  bit             no_stall;   // receiver keeps ready up, sender sends back to back
  bit [31:0]      last_lon, last_lat;

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // Hard stop in case the handshake hangs.
  initial begin
    #10_000_000;
    $display("FAIL stationary_point_detector");
    $finish;
  end

  // Send one ping: optional idle gap, then hold valid until the transfer.
  // Inputs move on the falling edge only; valid stays high into the next ping
  // when there is no gap, so it is assigned once per edge.
  task automatic send_ping(bit [31:0] user, bit [31:0] lon, bit [31:0] lat,
                           bit [23:0] acc, bit prior);
    int gap;
    gap = no_stall ? 0 : $urandom_range(0, 4);
    repeat (gap) begin
      ping_ch.valid = 0;
      @(negedge clk);
    end
    ping_ch.valid      = 1;
    ping_ch.user_id    = user;
    ping_ch.longitude  = lon;
    ping_ch.latitude   = lat;
    ping_ch.accuracy   = acc;
    ping_ch.prior_flag = prior;
    do @(posedge clk); while (!ping_ch.ready);
    sb.note_ping(user, lon, lat, acc, prior);
    last_lon = lon;
    last_lat = lat;
    @(negedge clk);
  endtask

  // Radius writes only with the block drained; the extra cycles cover the
  // short new-anchor path even though every ping returns a result.
  task automatic write_radius(bit [22:0] r);
    ping_ch.valid = 0;
    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    cfg_we    = 1;
    cfg_wdata = r;
    @(negedge clk);
    cfg_we    = 0;
    sb.radius_m = r;
  endtask

  // Random ping: mostly small moves of a few users around the last position,
  // so the still test lands on both sides; the rest is wide noise.
  task automatic random_ping();
    bit [31:0] users[3] = '{32'h0000_0001, 32'hDEAD_BEEF, 32'h8000_0000};
    bit [31:0] user, lon, lat;
    bit [23:0] acc;
    int        pick;
    pick = $urandom_range(0, 99);
    user = ($urandom_range(0, 9) == 0) ? $urandom() : users[$urandom_range(0, 2)];
    if (pick < 70) begin
      lon = last_lon + $urandom_range(0, 4000) - 2000;
      lat = last_lat + $urandom_range(0, 4000) - 2000;
      acc = 24'($urandom_range(0, 2500));
    end else if (pick < 85) begin
      lon = $urandom();
      lat = $urandom_range(0, 32'h8000_0000) - 32'h4000_0000;
      acc = 24'($urandom_range(0, 24'hFF_FFFF));
    end else begin
      lon = $urandom();
      lat = $urandom();
      acc = 24'($urandom());
    end
    send_ping(user, lon, lat, acc, 1'($urandom_range(0, 1)));
  endtask

  // Result side: random ready gaps, checked at the rising edge of the transfer.
  initial begin
    int gap;
    res_ch.ready = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      gap = no_stall ? 0 : $urandom_range(0, 4);
      repeat (gap) begin
        res_ch.ready = 0;
        @(negedge clk);
      end
      res_ch.ready = 1;
      do @(posedge clk); while (!res_ch.valid);
      sb.check_result(res_ch.still, res_ch.distance);
    end
  end

  initial begin
    bit [22:0] radii[6] = '{23'd1, 23'd8388607, 23'd0, 23'd6371000, 23'd4242,
                            spd_pkg::RADIUS_RESET};
    sb = new();
    no_stall           = 0;
    rst_n              = 0;
    cfg_we             = 0;
    cfg_wdata          = 0;
    ping_ch.valid      = 0;
    ping_ch.user_id    = 0;
    ping_ch.longitude  = 0;
    ping_ch.latitude   = 0;
    ping_ch.accuracy   = 0;
    ping_ch.prior_flag = 0;
    repeat (6) @(negedge clk);
    rst_n = 1;
    @(negedge clk);

    // Directed pings at the reset radius.
    send_ping(32'd1, 32'd0, 32'd0, 24'd0, 1'b0);            // no anchor yet
    send_ping(32'd1, 32'd0, 32'd0, 24'd0, 1'b0);            // zero distance, zero accuracy
    send_ping(32'd1, 32'd0, 32'd0, 24'd16, 1'b1);           // still, anchor kept
    send_ping(32'd1, 32'h7FFF_FFFF, 32'h4000_0000, 24'hFF_FFFF, 1'b0); // pole
    send_ping(32'd1, 32'h8000_0000, 32'hC000_0000, 24'd0, 1'b0);       // other pole
    send_ping(32'd2, 32'd12345, 32'd0, 24'd100, 1'b1);      // user change
    send_ping(32'd2, 32'h8000_3039, 32'd0, 24'd100, 1'b1);  // antipode, fails, prior kept
    send_ping(32'hFFFF_FFFF, 32'd0, 32'h7FFF_FFFF, 24'd50, 1'b0); // latitude past range
    send_ping(32'hFFFF_FFFF, 32'd0, 32'h8000_0000, 24'd50, 1'b0);
    send_ping(32'hFFFF_FFFF, 32'd5, 32'h4000_0001, 24'd50, 1'b0);
    send_ping(32'd0, 32'd100, 32'd200, 24'd5000, 1'b0);
    send_ping(32'd0, 32'd1100, 32'd200, 24'd5000, 1'b0);    // close move, still
    send_ping(32'd0, 32'd1100, 32'd900, 24'd1, 1'b0);
    send_ping(32'd0, 32'h4000_0000, 32'd900, 24'd1, 1'b1);  // far move with prior set
    send_ping(32'd0, 32'h4000_0000, 32'hF000_0000, 24'hFF_FFFF, 1'b0); // huge accuracy

    // Random phases over several radius settings, extremes included.
    for (int ph = 0; ph < 6; ph++) begin
      write_radius(radii[ph]);
      no_stall = (ph == 2);
      for (int n = 0; n < 115; n++) random_ping();
    end
    no_stall = 0;
    ping_ch.valid = 0;

    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (300) @(negedge clk);
    if (sb.failures == 0 && sb.expected_q.size() == 0)
      $display("PASS stationary_point_detector");
    else
      $display("FAIL stationary_point_detector");
    $finish;
  end
endmodule
